// ===== hw/rtl/mfhp_pkg.sv =====
`timescale 1ns / 1ps

package mfhp_pkg;

  localparam logic [2:0] MaxLengthBytes = 3'd4;
  localparam logic [3:0] TypePublish    = 4'd3;
  localparam logic [3:0] TypeIdFirst    = 4'd4;
  localparam logic [3:0] TypeIdLast     = 4'd11;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_LEN,
    PH_ID_HI,
    PH_ID_LO,
    PH_SKIP
  } phase_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       first_byte;
  } in_item_t;

  typedef struct packed {
    logic [3:0]  packet_type;
    logic [1:0]  qos_level;
    logic        dup_flag;
    logic        retain_flag;
    logic [27:0] remaining_length;
    logic [2:0]  length_byte_count;
    logic        has_identifier;
    logic [15:0] packet_identifier;
    logic        length_error;
  } result_t;

  typedef struct packed {
    logic     valid;
    in_item_t item;
  } in_slot_t;

  typedef struct packed {
    logic    push;
    result_t result;
  } push_t;

endpackage

// ===== hw/rtl/mfhp_if.sv =====
`timescale 1ns / 1ps

interface mfhp_in_if
  import mfhp_pkg::*;
();
  logic     valid;
  logic     ready;
  in_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface mfhp_out_if
  import mfhp_pkg::*;
();
  logic    valid;
  logic    ready;
  result_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ===== hw/rtl/mqtt_fixed_header_parser_core.sv =====
`timescale 1ns / 1ps

// Channel  Dir  Payload                                      Handshake
// pkt_i    in   data_byte[7:0], first_byte                   valid/ready
// hdr_o    out  type, qos, dup, retain, length[27:0], count,  valid/ready
//               has_id, id[15:0], length_error
//
// One byte per cycle sustained while no result waits on a full result register;
// each byte passes an input register, then combinational decode into the result
// register, so a result is registered once its last header byte is decoded.
// Reset clears the decode phase and both stage valid flags; bytes before the
// first marked first byte are dropped.
// A stalled result holds the decode only when the next byte would produce a
// result too; other bytes keep flowing.

module mqtt_fixed_header_parser_core
  import mfhp_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  mfhp_in_if.sink    pkt_i,
  mfhp_out_if.source hdr_o
);

  in_slot_t slot;
  logic     consume;
  logic     out_free;
  push_t    push;

  mfhp_in_stage u_in_stage (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (pkt_i.valid),
    .ready_o   (pkt_i.ready),
    .item_i    (pkt_i.payload),
    .consume_i (consume),
    .slot_o    (slot)
  );

  mfhp_decode u_decode (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .slot_i     (slot),
    .out_free_i (out_free),
    .consume_o  (consume),
    .push_o     (push)
  );

  mfhp_out_stage u_out_stage (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .free_o   (out_free),
    .valid_o  (hdr_o.valid),
    .ready_i  (hdr_o.ready),
    .result_o (hdr_o.payload)
  );

endmodule

// ===== hw/rtl/mfhp_in_stage.sv =====
`timescale 1ns / 1ps

module mfhp_in_stage
  import mfhp_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     valid_i,
  output logic     ready_o,
  input  in_item_t item_i,
  input  logic     consume_i,
  output in_slot_t slot_o
);

  logic     valid_q, valid_d;
  in_item_t item_q;
  logic     load;

  assign ready_o = !valid_q || consume_i;
  assign load    = valid_i && ready_o;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (consume_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q <= item_i;
    end
  end

  assign slot_o.valid = valid_q;
  assign slot_o.item  = item_q;

endmodule

// ===== hw/rtl/mfhp_decode.sv =====
`timescale 1ns / 1ps

module mfhp_decode
  import mfhp_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  in_slot_t slot_i,
  input  logic     out_free_i,
  output logic     consume_o,
  output push_t    push_o
);

  phase_e      phase_q, phase_d;
  logic [7:0]  hdr_q;
  logic [27:0] len_q;
  logic [2:0]  cnt_q;
  logic [7:0]  idhi_q;

  logic [7:0]  b;
  logic        first;
  logic [3:0]  hdr_type;
  logic        needs_id;
  logic [27:0] addend;
  logic [27:0] len_sum;
  logic [2:0]  cnt_inc;
  logic        len_err;
  logic        emit;

  assign b        = slot_i.item.data_byte;
  assign first    = slot_i.item.first_byte;
  assign hdr_type = hdr_q[7:4];
  assign needs_id = (hdr_type >= TypeIdFirst && hdr_type <= TypeIdLast) ||
                    (hdr_type == TypePublish && hdr_q[2:1] != 2'd0);

  always_comb begin
    unique case (cnt_q[1:0])
      2'd0:    addend = {21'd0, b[6:0]};
      2'd1:    addend = {14'd0, b[6:0], 7'd0};
      2'd2:    addend = {7'd0, b[6:0], 14'd0};
      default: addend = {b[6:0], 21'd0};
    endcase
  end

  assign len_sum = len_q + addend;
  assign cnt_inc = cnt_q + 3'd1;
  assign len_err = b[7] && (cnt_inc >= MaxLengthBytes);

  assign emit = slot_i.valid && !first &&
                ((phase_q == PH_LEN && (len_err || (!b[7] && !needs_id))) ||
                 phase_q == PH_ID_LO);
  assign consume_o = slot_i.valid && (!emit || out_free_i);

  // next state
  always_comb begin
    phase_d = phase_q;
    if (consume_o) begin
      if (first) begin
        phase_d = PH_LEN;
      end else begin
        unique case (phase_q)
          PH_LEN: begin
            if (len_err) begin
              phase_d = PH_SKIP;
            end else if (!b[7]) begin
              phase_d = needs_id ? PH_ID_HI : PH_SKIP;
            end
          end
          PH_ID_HI: phase_d = PH_ID_LO;
          PH_ID_LO: phase_d = PH_SKIP;
          default:  phase_d = phase_q;
        endcase
      end
    end
  end

  // result
  always_comb begin
    push_o.push                     = emit && consume_o;
    push_o.result.packet_type       = hdr_q[7:4];
    push_o.result.qos_level         = hdr_q[2:1];
    push_o.result.dup_flag          = hdr_q[3];
    push_o.result.retain_flag       = hdr_q[0];
    push_o.result.remaining_length  = len_sum;
    push_o.result.length_byte_count = cnt_inc;
    push_o.result.has_identifier    = 1'b0;
    push_o.result.packet_identifier = 16'd0;
    push_o.result.length_error      = 1'b0;
    if (phase_q == PH_ID_LO) begin
      push_o.result.remaining_length  = len_q;
      push_o.result.length_byte_count = cnt_q;
      push_o.result.has_identifier    = 1'b1;
      push_o.result.packet_identifier = {idhi_q, b};
    end else if (len_err) begin
      push_o.result.remaining_length = 28'd0;
      push_o.result.length_error     = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
    end else begin
      phase_q <= phase_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (consume_o) begin
      if (first) begin
        hdr_q <= b;
        len_q <= 28'd0;
        cnt_q <= 3'd0;
      end else if (phase_q == PH_LEN) begin
        len_q <= len_sum;
        cnt_q <= cnt_inc;
      end else if (phase_q == PH_ID_HI) begin
        idhi_q <= b;
      end
    end
  end

  a_first_starts_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    consume_o && first |=> phase_q == PH_LEN)
    else $error("first byte did not restart length decode");

  a_len_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_LEN |-> cnt_q < MaxLengthBytes)
    else $error("length byte count out of range");

  a_push_ends_header: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o.push && !first |=> phase_q == PH_SKIP)
    else $error("result given without closing the header");

  a_no_push_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o.push |-> out_free_i && slot_i.valid)
    else $error("result pushed into a full output register");

endmodule

// ===== hw/rtl/mfhp_out_stage.sv =====
`timescale 1ns / 1ps

module mfhp_out_stage
  import mfhp_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  push_t   push_i,
  output logic    free_o,
  output logic    valid_o,
  input  logic    ready_i,
  output result_t result_o
);

  logic    valid_q, valid_d;
  result_t result_q;

  assign free_o = !valid_q || ready_i;

  always_comb begin
    valid_d = valid_q;
    if (push_i.push) begin
      valid_d = 1'b1;
    end else if (ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.push) begin
      result_q <= push_i.result;
    end
  end

  assign valid_o  = valid_q;
  assign result_o = result_q;

endmodule
